// File: rtl/core/i2cm_pkg.sv
// Package with shared types and constants for the I2C master transaction engine.
`timescale 1ns / 1ps
`default_nettype none
package i2cm_pkg;
    localparam int BufferDepthDefault = 16;
    localparam int CfgAddrWidth = 3;

    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_LOAD  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;
    localparam logic [1:0] KIND_READ  = 2'd3;

    localparam logic [2:0] REG_TARGET_ADDRESS = 3'd0;
    localparam logic [2:0] REG_ACK_WAIT_TICKS = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ADDR_NAK = 2'd1;
    localparam logic [1:0] ST_DATA_NAK = 2'd2;

    typedef enum logic [3:0] {
        PH_IDLE, PH_START, PH_TX, PH_ACK0, PH_ACK1, PH_POLL, PH_ACKEND,
        PH_RX0, PH_RXHI, PH_RXLO, PH_MACK, PH_STOP
    } t_phase;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic [4:0] byte_count;
        logic       sda_in;
    } t_req;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       read_valid;
        logic [7:0] read_data;
        logic       done_res;
        logic [1:0] status;
    } t_res;
endpackage
`default_nettype wire

// File: rtl/core/i2cm_if.sv
// Valid/ready channel interfaces for requests and results.
`timescale 1ns / 1ps
`default_nettype none
interface i2cm_req_if;
    logic valid;
    logic ready;
    i2cm_pkg::t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface i2cm_res_if;
    logic valid;
    logic ready;
    i2cm_pkg::t_res payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: rtl/core/i2c_master_transaction_engine.sv
// Top level of the I2C master transaction engine.
`timescale 1ns / 1ps
`default_nettype none
// Each request is one delay tick, a buffer load or a transaction start, and
// gives exactly one result. A request is taken every clock cycle unless the
// result port stalls: a two-entry queue feeds the bus sequencer, which steps
// once per tick request and registers its result. The user must write the
// registers over the APB port only while idle; the block does not enforce it.
module i2c_master_transaction_engine #(
    parameter int BufferDepth = i2cm_pkg::BufferDepthDefault
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    i2cm_req_if.sink                               i_req,
    i2cm_res_if.source                             o_res,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [i2cm_pkg::CfgAddrWidth-1:0] paddr,
    input  wire logic [31:0]                       pwdata,
    output logic      [31:0]                       prdata,
    output logic                                   pready
);
    import i2cm_pkg::*;

    logic [6:0] r_target_address;
    logic [7:0] r_ack_wait_ticks;
    logic       avail, pop;
    t_req       head;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_address <= 7'd0;
            r_ack_wait_ticks <= 8'd8;
        end else if (psel && penable && pwrite) begin
            case (paddr)
                REG_TARGET_ADDRESS: r_target_address <= pwdata[6:0];
                REG_ACK_WAIT_TICKS: r_ack_wait_ticks <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr)
            REG_TARGET_ADDRESS: prdata = {25'd0, r_target_address};
            REG_ACK_WAIT_TICKS: prdata = {24'd0, r_ack_wait_ticks};
            default:            prdata = 32'd0;
        endcase
    end

    i2cm_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (i_req),
        .i_pop  (pop),
        .o_avail(avail),
        .o_head (head)
    );

    i2cm_back #(.BufferDepth(BufferDepth)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_avail         (avail),
        .i_head          (head),
        .o_pop           (pop),
        .i_target_address(r_target_address),
        .i_ack_wait_ticks(r_ack_wait_ticks),
        .o_res           (o_res)
    );
endmodule
`default_nettype wire

// File: rtl/core/i2cm_ram.sv
// Generic single-port write, registered-read RAM.
`timescale 1ns / 1ps
`default_nettype none
module i2cm_ram #(
    parameter int Width = 8,
    parameter int Depth = 16,
    parameter int AddrWidth = (Depth > 1) ? $clog2(Depth) : 1
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [AddrWidth-1:0] i_waddr,
    input  wire logic [Width-1:0]     i_wdata,
    input  wire logic [AddrWidth-1:0] i_raddr,
    output logic      [Width-1:0]     o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: rtl/core/i2cm_front.sv
// Front end: accepts requests into a two-entry queue.
`timescale 1ns / 1ps
`default_nettype none
module i2cm_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    i2cm_req_if.sink            i_req,
    input  wire logic           i_pop,
    output logic                o_avail,
    output i2cm_pkg::t_req      o_head
);
    import i2cm_pkg::*;

    t_req       r_q [2];
    logic [1:0] r_cnt;
    logic       push;

    assign i_req.ready = (r_cnt != 2'd2);
    assign push = i_req.valid && i_req.ready;
    assign o_avail = (r_cnt != 2'd0);
    assign o_head = r_q[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_pop};
        end
        if (i_pop) begin
            r_q[0] <= (push && r_cnt == 2'd1) ? i_req.payload : r_q[1];
            if (push && r_cnt == 2'd2) r_q[1] <= i_req.payload;
        end else if (push) begin
            if (r_cnt == 2'd0) r_q[0] <= i_req.payload;
            else r_q[1] <= i_req.payload;
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/i2cm_back.sv
// Back end: bus sequencer, write buffer and result register.
`timescale 1ns / 1ps
`default_nettype none
module i2cm_back #(
    parameter int BufferDepth = i2cm_pkg::BufferDepthDefault
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_avail,
    input  wire i2cm_pkg::t_req i_head,
    output logic                o_pop,
    input  wire logic [6:0]     i_target_address,
    input  wire logic [7:0]     i_ack_wait_ticks,
    i2cm_res_if.source          o_res
);
    import i2cm_pkg::*;

    localparam int AW = (BufferDepth > 1) ? $clog2(BufferDepth) : 1;
    localparam int PW = $clog2(BufferDepth + 1);
    localparam int CW = (PW > 5) ? PW : 5;

    t_phase     r_phase, n_phase;
    logic [1:0] r_sub, n_sub;
    logic [3:0] r_bit, n_bit;
    logic [4:0] r_rem, n_rem;
    logic [7:0] r_shift, n_shift;
    logic [7:0] r_wait, n_wait;
    logic       r_rmode, n_rmode;
    logic [PW-1:0] r_lptr, n_lptr;
    logic [CW-1:0] r_bidx, n_bidx;
    logic       r_sda, n_sda, r_nack, n_nack, r_inaddr, n_inaddr;
    logic [1:0] r_est, n_est;
    logic       r_hscl, n_hscl, r_hsda, n_hsda, r_hdrv, n_hdrv;
    logic       r_ovalid;
    t_res       r_res, n_res;
    logic       busy, go, we;
    logic [7:0] rdata_ram;
    logic [AW-1:0] raddr;
    logic [CW-1:0] cnt_ext;

    assign go = i_avail && (!r_ovalid || o_res.ready);
    assign o_pop = go;
    assign o_res.valid = r_ovalid;
    assign o_res.payload = r_res;
    assign busy = (r_phase != PH_IDLE);
    assign we = go && i_head.kind == KIND_LOAD && !busy && r_lptr < PW'(BufferDepth);
    assign cnt_ext = CW'(i_head.byte_count);

    // The read address follows the next byte index, so the registered read data matches the current byte index.
    assign raddr = AW'(n_bidx);

    i2cm_ram #(.Width(8), .Depth(BufferDepth), .AddrWidth(AW)) u_buf (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(AW'(r_lptr)),
        .i_wdata(i_head.data_byte),
        .i_raddr(raddr),
        .o_rdata(rdata_ram)
    );

    always_comb begin
        logic scl, drv, rv, dn, bz;
        logic [7:0] rd;
        logic [1:0] st;
        logic [7:0] sh;
        logic [3:0] bc;
        logic [4:0] cnt;
        n_phase = r_phase; n_sub = r_sub; n_bit = r_bit; n_rem = r_rem;
        n_shift = r_shift; n_wait = r_wait; n_rmode = r_rmode; n_lptr = r_lptr;
        n_bidx = r_bidx; n_sda = r_sda; n_nack = r_nack; n_inaddr = r_inaddr;
        n_est = r_est; n_hscl = r_hscl; n_hsda = r_hsda; n_hdrv = r_hdrv;
        scl = r_hscl; drv = r_hdrv; rv = 1'b0; dn = 1'b0; rd = 8'd0; st = ST_OK;
        bz = busy; sh = 8'd0; bc = 4'd0;
        cnt = i_head.byte_count;
        if (go) begin
            case (i_head.kind)
                KIND_LOAD: begin
                    if (we) n_lptr = r_lptr + PW'(1);
                end
                KIND_WRITE, KIND_READ: begin
                    if (!busy) begin
                        n_rmode = (i_head.kind == KIND_READ);
                        if (!n_rmode && cnt_ext > CW'(BufferDepth)) cnt = 5'(BufferDepth);
                        n_rem = cnt; n_bidx = '0; n_lptr = '0; n_inaddr = 1'b1;
                        n_nack = 1'b0; n_est = ST_OK; n_sub = 2'd0; n_phase = PH_START;
                        bz = 1'b1;
                    end
                end
                default: begin
                    if (busy) begin
                        case (r_phase)
                            PH_START: begin
                                drv = 1'b1;
                                if (r_sub == 2'd0) begin
                                    scl = 1'b1; n_sda = 1'b1; n_sub = 2'd1;
                                end else if (r_sub == 2'd1) begin
                                    scl = 1'b1; n_sda = 1'b0; n_sub = 2'd2;
                                end else begin
                                    scl = 1'b0;
                                    n_shift = {i_target_address, r_rmode};
                                    n_bit = 4'd0; n_sub = 2'd0; n_phase = PH_TX;
                                end
                            end
                            PH_TX: begin
                                drv = 1'b1;
                                case (r_sub)
                                    2'd0: begin scl = 1'b0; n_sub = 2'd1; end
                                    2'd1: begin
                                        n_sda = r_shift[7]; scl = 1'b0; n_sub = 2'd2;
                                    end
                                    2'd2: begin scl = 1'b1; n_sub = 2'd3; end
                                    default: begin
                                        scl = 1'b1;
                                        n_shift = {r_shift[6:0], 1'b0};
                                        n_bit = r_bit + 4'd1; n_sub = 2'd0;
                                        if (n_bit >= 4'd8) n_phase = PH_ACK0;
                                    end
                                endcase
                            end
                            PH_ACK0: begin
                                drv = 1'b1; scl = 1'b0; n_phase = PH_ACK1;
                            end
                            PH_ACK1: begin
                                drv = 1'b0; scl = 1'b1; n_wait = i_ack_wait_ticks;
                                if (i_ack_wait_ticks == 8'd0) begin
                                    n_nack = 1'b1; n_phase = PH_ACKEND;
                                end else begin
                                    n_phase = PH_POLL;
                                end
                            end
                            PH_POLL: begin
                                drv = 1'b0; scl = 1'b1;
                                if (!i_head.sda_in) begin
                                    n_nack = 1'b0; n_phase = PH_ACKEND;
                                end else begin
                                    n_wait = r_wait - 8'd1;
                                    if (n_wait == 8'd0) begin
                                        n_nack = 1'b1; n_phase = PH_ACKEND;
                                    end
                                end
                            end
                            PH_ACKEND: begin
                                drv = 1'b0; scl = 1'b0;
                                if (r_nack) begin
                                    n_est = r_inaddr ? ST_ADDR_NAK : ST_DATA_NAK;
                                    n_sub = 2'd0; n_phase = PH_STOP;
                                end else begin
                                    n_inaddr = 1'b0;
                                    if (r_rem == 5'd0) begin
                                        n_est = ST_OK; n_sub = 2'd0; n_phase = PH_STOP;
                                    end else if (r_rmode) begin
                                        n_phase = PH_RX0;
                                    end else begin
                                        n_shift = (r_bidx < CW'(BufferDepth)) ? rdata_ram
                                                                              : 8'd0;
                                        n_bidx = r_bidx + CW'(1);
                                        n_rem = r_rem - 5'd1;
                                        n_bit = 4'd0; n_sub = 2'd0; n_phase = PH_TX;
                                    end
                                end
                            end
                            PH_RX0: begin
                                drv = 1'b0; scl = 1'b0; n_bit = 4'd0; n_phase = PH_RXHI;
                            end
                            PH_RXHI: begin
                                drv = 1'b0; scl = 1'b1;
                                sh = {r_shift[6:0], i_head.sda_in};
                                bc = r_bit + 4'd1;
                                n_shift = sh; n_bit = bc;
                                if (bc >= 4'd8) begin rv = 1'b1; rd = sh; end
                                n_phase = PH_RXLO;
                            end
                            PH_RXLO: begin
                                drv = 1'b0; scl = 1'b0;
                                if (r_bit >= 4'd8) begin
                                    n_sub = 2'd0; n_phase = PH_MACK;
                                end else begin
                                    n_phase = PH_RXHI;
                                end
                            end
                            PH_MACK: begin
                                drv = 1'b1;
                                case (r_sub)
                                    2'd0: begin n_sda = 1'b0; scl = 1'b0; n_sub = 2'd1; end
                                    2'd1: begin
                                        n_sda = (r_rem == 5'd1); scl = 1'b0; n_sub = 2'd2;
                                    end
                                    2'd2: begin scl = 1'b1; n_sub = 2'd3; end
                                    default: begin
                                        scl = 1'b0;
                                        n_rem = r_rem - 5'd1;
                                        n_bidx = r_bidx + CW'(1);
                                        if (n_rem == 5'd0) begin
                                            n_est = ST_OK; n_sub = 2'd0; n_phase = PH_STOP;
                                        end else begin
                                            n_phase = PH_RX0;
                                        end
                                    end
                                endcase
                            end
                            default: begin
                                drv = 1'b1;
                                if (r_sub == 2'd0) begin
                                    scl = 1'b0; n_sda = 1'b0; n_sub = 2'd1;
                                end else if (r_sub == 2'd1) begin
                                    scl = 1'b1; n_sub = 2'd2;
                                end else begin
                                    scl = 1'b1; n_sda = 1'b1; dn = 1'b1; st = r_est;
                                    n_phase = PH_IDLE; n_sub = 2'd0;
                                end
                            end
                        endcase
                        n_hscl = scl; n_hdrv = drv; n_hsda = drv ? n_sda : 1'b0;
                    end
                end
            endcase
        end
        n_res.scl_level = n_hscl;
        n_res.sda_level = n_hsda;
        n_res.sda_drive = n_hdrv;
        n_res.busy_res = bz;
        n_res.read_valid = rv;
        n_res.read_data = rd;
        n_res.done_res = dn;
        n_res.status = st;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE; r_sub <= 2'd0; r_bit <= 4'd0; r_rem <= 5'd0;
            r_shift <= 8'd0; r_wait <= 8'd0; r_rmode <= 1'b0; r_lptr <= '0;
            r_bidx <= '0; r_sda <= 1'b1; r_nack <= 1'b0; r_inaddr <= 1'b0;
            r_est <= ST_OK; r_hscl <= 1'b1; r_hsda <= 1'b1; r_hdrv <= 1'b1;
            r_ovalid <= 1'b0;
        end else begin
            r_phase <= n_phase; r_sub <= n_sub; r_bit <= n_bit; r_rem <= n_rem;
            r_shift <= n_shift; r_wait <= n_wait; r_rmode <= n_rmode; r_lptr <= n_lptr;
            r_bidx <= n_bidx; r_sda <= n_sda; r_nack <= n_nack; r_inaddr <= n_inaddr;
            r_est <= n_est; r_hscl <= n_hscl; r_hsda <= n_hsda; r_hdrv <= n_hdrv;
            if (go) r_ovalid <= 1'b1;
            else if (o_res.ready) r_ovalid <= 1'b0;
        end
        if (go) r_res <= n_res;
    end
endmodule
`default_nettype wire
